// ----- hw/rtl/trfa_pkg.sv -----
// ----------------------------------------------------------------------------
// trfa_pkg : shared types and constants of the temporary register file ALU
// Field widths, operation codes, sequencer states and divider control.
// ----------------------------------------------------------------------------
package trfa_pkg;

  localparam int KIND_W         = 5;
  localparam int IDX_W          = 12;
  localparam int DATA_W         = 32;
  localparam int TEMP_COUNT_DEF = 4096;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOADIMM = 5'd0,
    KIND_MOVE    = 5'd1,
    KIND_ADD     = 5'd2,
    KIND_SUB     = 5'd3,
    KIND_MUL     = 5'd4,
    KIND_DIV     = 5'd5,
    KIND_MOD     = 5'd6,
    KIND_NEG     = 5'd7,
    KIND_LNOT    = 5'd8,
    KIND_BNOT    = 5'd9,
    KIND_EQ      = 5'd10,
    KIND_NE      = 5'd11,
    KIND_LT      = 5'd12,
    KIND_GT      = 5'd13,
    KIND_LE      = 5'd14,
    KIND_GE      = 5'd15,
    KIND_LAND    = 5'd16,
    KIND_LOR     = 5'd17,
    KIND_BAND    = 5'd18,
    KIND_BOR     = 5'd19,
    KIND_BXOR    = 5'd20,
    KIND_SHL     = 5'd21,
    KIND_SHR     = 5'd22,
    KIND_READ    = 5'd23
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_B,
    ST_EXEC,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic start;
    logic is_mod;
  } div_ctrl_t;

endpackage

// ----- hw/rtl/trfa_in_if.sv -----
// ----------------------------------------------------------------------------
// trfa_in_if : operation request channel
// Valid/ready channel carrying one three-address operation.
// ----------------------------------------------------------------------------
interface trfa_in_if;
  import trfa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [IDX_W-1:0]         target;
  logic [IDX_W-1:0]         first_source;
  logic [IDX_W-1:0]         second_source;
  logic signed [DATA_W-1:0] immediate;

  modport source (
    output valid, kind, target, first_source, second_source, immediate,
    input  ready
  );

  modport sink (
    input  valid, kind, target, first_source, second_source, immediate,
    output ready
  );

endinterface

// ----- hw/rtl/trfa_out_if.sv -----
// ----------------------------------------------------------------------------
// trfa_out_if : result request channel
// Valid/ready channel carrying one operation result.
// ----------------------------------------------------------------------------
interface trfa_out_if;
  import trfa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     wrote_target;
  logic [IDX_W-1:0]         target_index;
  logic signed [DATA_W-1:0] result_value;
  logic                     result_is_zero;

  modport source (
    output valid, wrote_target, target_index, result_value, result_is_zero,
    input  ready
  );

  modport sink (
    input  valid, wrote_target, target_index, result_value, result_is_zero,
    output ready
  );

endinterface

// ----- hw/rtl/trfa_ram.sv -----
// ----------------------------------------------------------------------------
// trfa_ram : generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module trfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/trfa_div.sv -----
// ----------------------------------------------------------------------------
// trfa_div : iterative signed divider
// Restoring divider, one quotient bit per cycle, with sign fix-up.
// ----------------------------------------------------------------------------
module trfa_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  trfa_pkg::div_ctrl_t                ctrl,
  input  logic [trfa_pkg::DATA_W-1:0]        dividend,
  input  logic [trfa_pkg::DATA_W-1:0]        divisor,
  output logic                               done,
  output logic [trfa_pkg::DATA_W-1:0]        result
);
  import trfa_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] dvs_r, dvs_nxt;
  logic              neg_q_r, neg_q_nxt;
  logic              neg_r_r, neg_r_nxt;
  logic              zero_r, zero_nxt;
  logic              mod_r, mod_nxt;

  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              ge;

  assign trial = {rem_r, quo_r[DATA_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = !diff[DATA_W];

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    dvs_nxt   = dvs_r;
    neg_q_nxt = neg_q_r;
    neg_r_nxt = neg_r_r;
    zero_nxt  = zero_r;
    mod_nxt   = mod_r;
    if (busy_r) begin
      rem_nxt = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (ctrl.start) begin
      // take magnitudes; signs are applied on the way out
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      rem_nxt   = '0;
      quo_nxt   = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
      dvs_nxt   = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
      neg_q_nxt = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      neg_r_nxt = dividend[DATA_W-1];
      zero_nxt  = (divisor == '0);
      mod_nxt   = ctrl.is_mod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    dvs_r   <= dvs_nxt;
    neg_q_r <= neg_q_nxt;
    neg_r_r <= neg_r_nxt;
    zero_r  <= zero_nxt;
    mod_r   <= mod_nxt;
  end

  // zero divisor forces 0; INT_MIN / -1 wraps through the negation
  always_comb begin
    if (zero_r) begin
      result = '0;
    end else if (mod_r) begin
      result = neg_r_r ? (DATA_W'(0) - rem_r) : rem_r;
    end else begin
      result = neg_q_r ? (DATA_W'(0) - quo_r) : quo_r;
    end
  end

  assign done = done_r;

endmodule

// ----- hw/rtl/trfa_alu.sv -----
// ----------------------------------------------------------------------------
// trfa_alu : combinational operation unit
// Arithmetic, compare, logic and shift on two 32-bit operands.
// ----------------------------------------------------------------------------
module trfa_alu (
  input  trfa_pkg::kind_t                   kind,
  input  logic [trfa_pkg::DATA_W-1:0]       a,
  input  logic [trfa_pkg::DATA_W-1:0]       b,
  input  logic [trfa_pkg::DATA_W-1:0]       imm,
  output logic [trfa_pkg::DATA_W-1:0]       value,
  output logic                              writes
);
  import trfa_pkg::*;

  logic              a_lt_b;
  logic              b_lt_a;
  logic [4:0]        sh;
  logic [DATA_W-1:0] prod;

  assign a_lt_b = $signed(a) < $signed(b);
  assign b_lt_a = $signed(b) < $signed(a);
  assign sh     = b[4:0];
  assign prod   = a * b;

  always_comb begin
    value  = '0;
    writes = 1'b1;
    unique case (kind)
      KIND_LOADIMM: value = imm;
      KIND_MOVE:    value = a;
      KIND_ADD:     value = a + b;
      KIND_SUB:     value = a - b;
      KIND_MUL:     value = prod;
      KIND_DIV,
      KIND_MOD:     value = '0;
      KIND_NEG:     value = DATA_W'(0) - a;
      KIND_LNOT:    value = DATA_W'(a == '0);
      KIND_BNOT:    value = ~a;
      KIND_EQ:      value = DATA_W'(a == b);
      KIND_NE:      value = DATA_W'(a != b);
      KIND_LT:      value = DATA_W'(a_lt_b);
      KIND_GT:      value = DATA_W'(b_lt_a);
      KIND_LE:      value = DATA_W'(!b_lt_a);
      KIND_GE:      value = DATA_W'(!a_lt_b);
      KIND_LAND:    value = DATA_W'((a != '0) && (b != '0));
      KIND_LOR:     value = DATA_W'((a != '0) || (b != '0));
      KIND_BAND:    value = a & b;
      KIND_BOR:     value = a | b;
      KIND_BXOR:    value = a ^ b;
      KIND_SHL:     value = a << sh;
      KIND_SHR:     value = DATA_W'($signed(a) >>> sh);
      KIND_READ: begin
        value  = a;
        writes = 1'b0;
      end
      default: begin
        value  = '0;
        writes = 1'b0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/temp_register_file_alu.sv -----
// ----------------------------------------------------------------------------
// temp_register_file_alu : three-address ALU on a store of temporaries
// Reads up to two temporaries, computes one result, writes it back.
// ----------------------------------------------------------------------------
//
// Channel   Role    Carries
// in_req    sink    kind, target, first_source, second_source, immediate
// out_res   source  wrote_target, target_index, result_value, result_is_zero
//
// An item runs from acceptance in ST_IDLE through ST_RD_B, ST_EXEC and ST_FIN
// (read first operand, read second operand, execute, write back) before the next
// acceptance, as the RAM has a single read port; div and mod also pass through
// ST_DIV in the bit-serial divider. After reset a clearing pass zeroes the store,
// one entry at a time, while in_req.ready stays low.
// A stalled out_res holds the finished item in write-back; the store is only
// written once the result request is handed to the output register.
// ----------------------------------------------------------------------------
module temp_register_file_alu #(
  parameter int TEMP_COUNT = trfa_pkg::TEMP_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  trfa_in_if.sink     in_req,
  trfa_out_if.source  out_res
);
  import trfa_pkg::*;

  localparam int AW = $clog2(TEMP_COUNT);

  state_t state_r, state_nxt;

  // Captured request
  kind_t             kind_r, kind_nxt;
  logic [IDX_W-1:0]  tgt_r, tgt_nxt;
  logic [AW-1:0]     src_b_r, src_b_nxt;
  logic [DATA_W-1:0] imm_r, imm_nxt;
  logic              a_ok_r, a_ok_nxt;
  logic              b_ok_r, b_ok_nxt;
  logic              tgt_ok_r, tgt_ok_nxt;

  // Operand and result holding
  logic [DATA_W-1:0] a_r, a_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic              wr_r, wr_nxt;

  // Clearing pass
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_wrote_r, out_wrote_nxt;
  logic [IDX_W-1:0]  out_tgt_r, out_tgt_nxt;
  logic [DATA_W-1:0] out_val_r, out_val_nxt;
  logic              out_zero_r, out_zero_nxt;

  // RAM port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // Execute path
  logic [DATA_W-1:0] op_b;
  logic [DATA_W-1:0] alu_value;
  logic              alu_writes;
  div_ctrl_t         div_ctrl;
  logic              div_done;
  logic [DATA_W-1:0] div_result;

  logic              in_fire;
  logic              out_free;

  assign in_fire  = in_req.valid && in_req.ready;
  assign out_free = !out_valid_r || out_res.ready;
  assign op_b     = b_ok_r ? ram_rdata : '0;

  trfa_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TEMP_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  trfa_alu u_alu (
    .kind   (kind_r),
    .a      (a_r),
    .b      (op_b),
    .imm    (imm_r),
    .value  (alu_value),
    .writes (alu_writes)
  );

  trfa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (a_r),
    .divisor  (op_b),
    .done     (div_done),
    .result   (div_result)
  );

  // Sequencer: next state, datapath loads, RAM control
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    tgt_nxt       = tgt_r;
    src_b_nxt     = src_b_r;
    imm_nxt       = imm_r;
    a_ok_nxt      = a_ok_r;
    b_ok_nxt      = b_ok_r;
    tgt_ok_nxt    = tgt_ok_r;
    a_nxt         = a_r;
    res_nxt       = res_r;
    wr_nxt        = wr_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    out_wrote_nxt = out_wrote_r;
    out_tgt_nxt   = out_tgt_r;
    out_val_nxt   = out_val_r;
    out_zero_nxt  = out_zero_r;
    ram_we        = 1'b0;
    ram_waddr     = AW'(tgt_r);
    ram_wdata     = res_r;
    ram_raddr     = src_b_r;
    div_ctrl      = '0;
    in_req.ready  = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        // zero one entry a cycle
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(TEMP_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // issue the first operand read straight from the request
        in_req.ready = 1'b1;
        ram_raddr    = AW'(in_req.first_source);
        if (in_fire) begin
          kind_nxt   = kind_t'(in_req.kind);
          tgt_nxt    = in_req.target;
          src_b_nxt  = AW'(in_req.second_source);
          imm_nxt    = in_req.immediate;
          a_ok_nxt   = 32'(in_req.first_source) < 32'(TEMP_COUNT);
          b_ok_nxt   = 32'(in_req.second_source) < 32'(TEMP_COUNT);
          tgt_ok_nxt = 32'(in_req.target) < 32'(TEMP_COUNT);
          state_nxt  = ST_RD_B;
        end
      end
      ST_RD_B: begin
        // first operand lands; issue the second read
        a_nxt     = a_ok_r ? ram_rdata : '0;
        ram_raddr = src_b_r;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (kind_r == KIND_DIV || kind_r == KIND_MOD) begin
          div_ctrl.start  = 1'b1;
          div_ctrl.is_mod = (kind_r == KIND_MOD);
          state_nxt       = ST_DIV;
        end else begin
          res_nxt   = alu_value;
          wr_nxt    = alu_writes;
          state_nxt = ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_nxt   = div_result;
          wr_nxt    = 1'b1;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register is free, then write back
        if (out_free) begin
          ram_we        = wr_r && tgt_ok_r;
          ram_waddr     = AW'(tgt_r);
          ram_wdata     = res_r;
          out_valid_nxt = 1'b1;
          out_wrote_nxt = wr_r && tgt_ok_r;
          out_tgt_nxt   = tgt_r;
          out_val_nxt   = res_r;
          out_zero_nxt  = (res_r == '0);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    tgt_r       <= tgt_nxt;
    src_b_r     <= src_b_nxt;
    imm_r       <= imm_nxt;
    a_ok_r      <= a_ok_nxt;
    b_ok_r      <= b_ok_nxt;
    tgt_ok_r    <= tgt_ok_nxt;
    a_r         <= a_nxt;
    res_r       <= res_nxt;
    wr_r        <= wr_nxt;
    out_wrote_r <= out_wrote_nxt;
    out_tgt_r   <= out_tgt_nxt;
    out_val_r   <= out_val_nxt;
    out_zero_r  <= out_zero_nxt;
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.wrote_target   = out_wrote_r;
  assign out_res.target_index   = out_tgt_r;
  assign out_res.result_value   = out_val_r;
  assign out_res.result_is_zero = out_zero_r;

endmodule
